[rtl/core/srfc_pkg.sv]
// Shared types, constants and CRC/header functions for the report framer.
package srfc_pkg;

  localparam int unsigned PayloadWords = 25;
  localparam int unsigned HdrWords     = 18;
  localparam int unsigned ReportWords  = 50;

  localparam logic [31:0] CRC_POLY     = 32'hEDB8_8320;
  localparam logic [7:0]  SEED_BYTE    = 8'hA2;

  localparam logic [3:0]  BCNT_FULL    = 4'd8;
  localparam logic [3:0]  BCNT_FINAL   = 4'd6;

  // Snapshot block placed at report bytes 13 to 75.
  localparam logic [7:0] SNAP_ROM [63] = '{
    8'hfd, 8'he3, 8'h00, 8'h00, 8'h7f, 8'h64, 8'h00, 8'h09, 8'h00, 8'h10,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h0a, 8'h04, 8'h00,
    8'h00, 8'h00, 8'h01, 8'h00, 8'h00, 8'h00, 8'hff, 8'h00, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h00
  };

  // One queued payload transaction, tagged by the front end.
  typedef struct packed {
    logic [63:0] payload;
    logic        last;
    logic        first;  // opens a new report, header goes out first
    logic        drop;   // beyond the payload area, not placed in the report
  } entry_t;

  function automatic logic [31:0] crc_byte(logic [31:0] c_in, logic [7:0] b);
    logic [31:0] c;
    c = c_in ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      c = (c >> 1) ^ (c[0] ? CRC_POLY : 32'd0);
    end
    return c;
  endfunction

  function automatic logic [31:0] crc_word(logic [31:0] c_in, logic [63:0] w);
    logic [31:0] c;
    c = c_in;
    for (int k = 0; k < 8; k++) begin
      c = crc_byte(c, w[8*k +: 8]);
    end
    return c;
  endfunction

  localparam logic [31:0] CRC_SEED = crc_byte(32'hFFFF_FFFF, SEED_BYTE);

  function automatic logic [7:0] hdr_byte(logic [7:0] bi, logic [3:0] seq,
                                          logic [7:0] frame);
    logic [7:0] r;
    r = 8'h00;
    priority if (bi == 8'd0) begin
      r = 8'h36;
    end else if (bi == 8'd1) begin
      r = {seq, 4'h0};
    end else if (bi == 8'd2) begin
      r = 8'h91;
    end else if (bi == 8'd3) begin
      r = 8'h07;
    end else if (bi == 8'd4) begin
      r = 8'hFF;
    end else if (bi >= 8'd5 && bi <= 8'd9) begin
      r = 8'd64;
    end else if (bi == 8'd10) begin
      r = frame;
    end else if (bi == 8'd11) begin
      r = 8'h90;
    end else if (bi == 8'd12) begin
      r = 8'd63;
    end else if (bi >= 8'd13 && bi <= 8'd75) begin
      r = SNAP_ROM[6'(bi - 8'd13)];
    end else if (bi == 8'd76) begin
      r = 8'h92;
    end else if (bi == 8'd77) begin
      r = 8'd64;
    end else if (bi == 8'd142) begin
      r = 8'h93;
    end else if (bi == 8'd143) begin
      r = 8'd200;
    end else begin
      r = 8'h00;
    end
    return r;
  endfunction

  function automatic logic [63:0] hdr_word(logic [4:0] widx, logic [3:0] seq,
                                           logic [7:0] frame);
    logic [63:0] w;
    logic [7:0]  bi;
    w = '0;
    for (int j = 0; j < 8; j++) begin
      bi = {widx, 3'b000} + 8'(j);
      w[8*j +: 8] = hdr_byte(bi, seq, frame);
    end
    return w;
  endfunction

endpackage

[rtl/core/srfc_front.sv]
// Input side: accepts payload transactions and tags them for the back end.
module srfc_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_valid_i,
  output logic                 s_ready_o,
  input  logic [63:0]          payload_i,
  input  logic                 last_i,
  output logic                 push_o,
  output srfc_pkg::entry_t     entry_o,
  input  logic                 full_i
);

  logic       in_pkt_q, in_pkt_d;
  logic [4:0] cnt_q, cnt_d;
  logic       full_area;

  assign s_ready_o = !full_i;
  assign push_o    = s_valid_i && !full_i;
  assign full_area = (cnt_q == 5'(srfc_pkg::PayloadWords));

  always_comb begin
    entry_o.payload = payload_i;
    entry_o.last    = last_i;
    entry_o.first   = !in_pkt_q;
    entry_o.drop    = full_area;
  end

  always_comb begin
    in_pkt_d = in_pkt_q;
    cnt_d    = cnt_q;
    if (push_o) begin
      if (last_i) begin
        in_pkt_d = 1'b0;
        cnt_d    = '0;
      end else begin
        in_pkt_d = 1'b1;
        cnt_d    = full_area ? cnt_q : cnt_q + 5'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_pkt_q <= 1'b0;
      cnt_q    <= '0;
    end else begin
      in_pkt_q <= in_pkt_d;
      cnt_q    <= cnt_d;
    end
  end

endmodule

[rtl/core/srfc_queue.sv]
// Short queue of tagged payload transactions between front and back end.
module srfc_queue #(
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  srfc_pkg::entry_t push_data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             head_valid_o,
  output srfc_pkg::entry_t head_o
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  srfc_pkg::entry_t slots_q [DEPTH];
  logic [PtrW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]  cnt_q;
  logic             do_push, do_pop;

  assign full_o       = (cnt_q == CntW'(DEPTH));
  assign head_valid_o = (cnt_q != '0);
  assign head_o       = slots_q[rd_ptr_q];
  assign do_push      = push_i && !full_o;
  assign do_pop       = pop_i && head_valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slots_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + PtrW'(1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

endmodule

[rtl/core/srfc_back.sv]
// Report sequencer: header, payload, fill and CRC words into an output register.
module srfc_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             head_valid_i,
  input  srfc_pkg::entry_t head_i,
  output logic             pop_o,
  output logic             m_valid_o,
  input  logic             m_ready_i,
  output logic [63:0]      word_o,
  output logic [3:0]       bcnt_o,
  output logic             eor_o,
  output logic             ovf_o
);

  typedef enum logic [4:0] {
    ST_WAIT = 5'b00001,
    ST_HDR  = 5'b00010,
    ST_PAY  = 5'b00100,
    ST_FILL = 5'b01000,
    ST_FIN  = 5'b10000
  } state_e;

  state_e      st_q, st_d;
  logic [5:0]  widx_q, widx_d;
  logic [3:0]  seq_q, seq_d;
  logic [7:0]  frame_q, frame_d;
  logic [31:0] crc_q, crc_d;
  logic        drop_q, drop_d;
  logic        vld_q, vld_d;
  logic [63:0] word_q, word_d;
  logic        fin_q, fin_d;
  logic        ovf_q, ovf_d;
  logic        adv;
  logic [31:0] crc_tail;

  assign adv      = !vld_q || m_ready_i;
  assign crc_tail = srfc_pkg::crc_byte(srfc_pkg::crc_byte(crc_q, 8'h00), 8'h00);

  always_comb begin
    st_d    = st_q;
    widx_d  = widx_q;
    seq_d   = seq_q;
    frame_d = frame_q;
    crc_d   = crc_q;
    drop_d  = drop_q;
    vld_d   = vld_q && !m_ready_i;
    word_d  = word_q;
    fin_d   = fin_q;
    ovf_d   = ovf_q;
    pop_o   = 1'b0;

    unique case (st_q)
      ST_WAIT: begin
        if (head_valid_i) begin
          if (head_i.first) begin
            st_d = ST_HDR;
          end else if (!head_i.drop) begin
            st_d = ST_PAY;
          end else begin
            drop_d = 1'b1;
            if (head_i.last) begin
              st_d = ST_FILL;
            end else begin
              pop_o = 1'b1;
            end
          end
        end
      end
      ST_HDR: begin
        if (adv) begin
          word_d = srfc_pkg::hdr_word(widx_q[4:0], seq_q, frame_q);
          if (widx_q == 6'(srfc_pkg::HdrWords - 1)) begin
            st_d = ST_PAY;
          end
        end
      end
      ST_PAY: begin
        if (adv) begin
          word_d = head_i.payload;
          if (head_i.last) begin
            st_d = ST_FILL;
          end else begin
            pop_o = 1'b1;
            st_d  = ST_WAIT;
          end
        end
      end
      ST_FILL: begin
        if (adv) begin
          word_d = '0;
          if (widx_q == 6'(srfc_pkg::ReportWords - 2)) begin
            st_d = ST_FIN;
          end
        end
      end
      ST_FIN: begin
        if (adv) begin
          word_d = {16'h0000, ~crc_tail, 16'h0000};
          pop_o  = 1'b1;
          st_d   = ST_WAIT;
        end
      end
      default: begin
        st_d = ST_WAIT;
      end
    endcase

    // Any state but the wait state puts out one word when the register frees up.
    if (adv && (st_q != ST_WAIT)) begin
      vld_d = 1'b1;
      ovf_d = drop_q;
      if (st_q == ST_FIN) begin
        fin_d   = 1'b1;
        widx_d  = '0;
        crc_d   = srfc_pkg::CRC_SEED;
        drop_d  = 1'b0;
        seq_d   = seq_q + 4'd1;
        frame_d = frame_q + 8'd1;
      end else begin
        fin_d  = 1'b0;
        widx_d = widx_q + 6'd1;
        crc_d  = srfc_pkg::crc_word(crc_q, word_d);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q    <= ST_WAIT;
      widx_q  <= '0;
      seq_q   <= '0;
      frame_q <= '0;
      crc_q   <= srfc_pkg::CRC_SEED;
      drop_q  <= 1'b0;
      vld_q   <= 1'b0;
    end else begin
      st_q    <= st_d;
      widx_q  <= widx_d;
      seq_q   <= seq_d;
      frame_q <= frame_d;
      crc_q   <= crc_d;
      drop_q  <= drop_d;
      vld_q   <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    word_q <= word_d;
    fin_q  <= fin_d;
    ovf_q  <= ovf_d;
  end

  assign m_valid_o = vld_q;
  assign word_o    = word_q;
  assign bcnt_o    = fin_q ? srfc_pkg::BCNT_FINAL : srfc_pkg::BCNT_FULL;
  assign eor_o     = fin_q;
  assign ovf_o     = ovf_q;

endmodule

[rtl/core/speaker_report_framer_crc32_core.sv]
// Top level of the audio report framer with CRC-32.
//
//   Channel  Dir  tdata          tuser                       tlast
//   s_axis   in   payload_word   (none)                      last_word
//   m_axis   out  report_word    byte_count, overflow_flag   end_of_report
//
// The back end decodes each queued payload transaction in its wait state, then puts
// out the report words that it causes. Every report is 50 words out, whatever the
// packet length, and a dropped transaction costs only a decode. The first word of a
// report passes through the queue and the decode before it leaves. Reset clears the
// counters, the CRC and the queue at once; a stalled output holds the back end, and
// tready drops once the queue fills.
module speaker_report_framer_crc32_core #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [63:0] s_axis_tdata_i,   // [63:0] payload_word
  input  logic        s_axis_tlast_i,   // last_word
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [63:0] m_axis_tdata_o,   // [63:0] report_word
  output logic        m_axis_tlast_o,   // end_of_report
  output logic [7:0]  m_axis_tuser_o    // [3:0] byte_count, [4] overflow_flag, [7:5] zero
);

  srfc_pkg::entry_t push_entry;
  srfc_pkg::entry_t head_entry;
  logic             push;
  logic             full;
  logic             head_valid;
  logic             pop;
  logic [3:0]       bcnt;
  logic             ovf;

  // The front end tags each transaction: opens a report, lands past the payload area.
  srfc_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid_i),
    .s_ready_o (s_axis_tready_o),
    .payload_i (s_axis_tdata_i),
    .last_i    (s_axis_tlast_i),
    .push_o    (push),
    .entry_o   (push_entry),
    .full_i    (full)
  );

  srfc_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_data_i  (push_entry),
    .full_o       (full),
    .pop_i        (pop),
    .head_valid_o (head_valid),
    .head_o       (head_entry)
  );

  // The back end walks the report, keeps the running CRC and owns the output register.
  srfc_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (head_valid),
    .head_i       (head_entry),
    .pop_o        (pop),
    .m_valid_o    (m_axis_tvalid_o),
    .m_ready_i    (m_axis_tready_i),
    .word_o       (m_axis_tdata_o),
    .bcnt_o       (bcnt),
    .eor_o        (m_axis_tlast_o),
    .ovf_o        (ovf)
  );

  assign m_axis_tuser_o = {3'b000, ovf, bcnt};

endmodule

[dv/tb_top.sv]
// Self-checking testbench for the audio report framer with CRC-32.
`timescale 1ns / 100ps

module tb_top;

  // Byte counts carried in the low tuser nibble.
  localparam logic [3:0]  NBYTES_FULL   = 4'd8;
  localparam logic [3:0]  NBYTES_FINAL  = 4'd6;
  localparam int unsigned SLOTS         = 25;   // payload words per report
  localparam int unsigned HEADER_WORDS  = 18;
  localparam int unsigned FILL_WORDS    = 6;
  localparam logic [31:0] CRC_REFLECTED = 32'hEDB8_8320;
  localparam logic [7:0]  CRC_PRELUDE   = 8'hA2;
  localparam int unsigned RANDOM_ITEMS  = 400;
  localparam int unsigned CALM_TAIL     = 60;   // last items sent without idling
  localparam int unsigned DRAIN_CYCLES  = 100;

  // One expected report word as it should leave the master side.
  typedef struct {
    logic [63:0] word;
    logic [3:0]  nbytes;
    logic        closing;
    logic        spill;
  } report_beat_t;

  // One row of the directed stimulus. Where typed is set, header_w0 is the
  // first word the transaction must bring out, written down by hand.
  typedef struct {
    logic [63:0] payload;
    logic        last;
    logic        typed;
    logic [63:0] header_w0;
  } directed_row_t;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid_i;
  logic        s_axis_tready_o;
  logic [63:0] s_axis_tdata_i;
  logic        s_axis_tlast_i;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i;
  logic [63:0] m_axis_tdata_o;
  logic        m_axis_tlast_o;
  logic [7:0]  m_axis_tuser_o;

  // Mirror of the framer state, advanced on each accepted payload transaction.
  logic [3:0]  seq_nib;
  logic [7:0]  frame_cnt;
  int unsigned slot_cnt;
  logic [31:0] crc_acc;
  logic        spill_seen;
  logic        report_open;

  report_beat_t report_q[$];
  int unsigned  mismatches;
  int unsigned  beats_seen;
  int unsigned  items_sent;

  // Idling controls, changed before each directed row and each random packet by the stimulus process.
  logic src_gappy;
  logic sink_calm;

  speaker_report_framer_crc32_core uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tlast_i  (s_axis_tlast_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tlast_o  (m_axis_tlast_o),
    .m_axis_tuser_o  (m_axis_tuser_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Watchdog. The slowest legal run (every word held off by the longest sink
  // stall) stays under a fifth of this.
  initial begin
    #(20_000_000);
    $display("FAILURE");
    $finish;
  end

  // Reflected CRC-32, one byte at a time, bit by bit.
  function automatic logic [31:0] crc_feed(input logic [31:0] acc, input logic [7:0] b);
    logic [31:0] r;
    logic        fb;
    r = acc;
    for (int k = 0; k < 8; k++) begin
      fb = r[0] ^ b[k];
      r  = r >> 1;
      if (fb) begin
        r = r ^ CRC_REFLECTED;
      end
    end
    return r;
  endfunction

  // Snapshot block at report bytes 13 to 75; only a few bytes are nonzero.
  function automatic logic [7:0] snapshot_byte(input int unsigned i);
    case (i)
      0:       return 8'hfd;
      1:       return 8'he3;
      4:       return 8'h7f;
      5:       return 8'h64;
      7:       return 8'h09;
      9:       return 8'h10;
      37:      return 8'h0a;
      38:      return 8'h04;
      42:      return 8'h01;
      46:      return 8'hff;
      default: return 8'h00;
    endcase
  endfunction

  function automatic logic [7:0] header_byte(input int unsigned i, input logic [3:0] seq,
                                             input logic [7:0] frame);
    if (i == 0)                 return 8'h36;
    else if (i == 1)            return {seq, 4'h0};
    else if (i == 2)            return 8'h91;
    else if (i == 3)            return 8'h07;
    else if (i == 4)            return 8'hFF;
    else if (i >= 5 && i <= 9)  return 8'd64;
    else if (i == 10)           return frame;
    else if (i == 11)           return 8'h90;
    else if (i == 12)           return 8'd63;
    else if (i >= 13 && i <= 75) return snapshot_byte(i - 13);
    else if (i == 76)           return 8'h92;
    else if (i == 77)           return 8'd64;
    else if (i == 142)          return 8'h93;
    else if (i == 143)          return 8'd200;
    else                        return 8'h00;
  endfunction

  task automatic report_mismatch(input string what);
    $display("%0t ns: mismatch: %s", $time, what);
    mismatches++;
  endtask

  // Back to the idle state between reports: CRC preloaded with the prelude byte.
  task automatic clear_report_state();
    slot_cnt    = 0;
    crc_acc     = crc_feed(32'hFFFF_FFFF, CRC_PRELUDE);
    spill_seen  = 1'b0;
    report_open = 1'b0;
  endtask

  // A full eight-byte word: folded into the CRC and queued as expected.
  task automatic frame_word(input logic [63:0] w);
    for (int k = 0; k < 8; k++) begin
      crc_acc = crc_feed(crc_acc, w[8*k +: 8]);
    end
    report_q.push_back('{w, NBYTES_FULL, 1'b0, spill_seen});
  endtask

  // Expected report words caused by one accepted payload transaction.
  task automatic predict_report(input logic [63:0] payload, input logic last);
    logic [63:0] hw;
    if (!report_open) begin
      for (int wi = 0; wi < HEADER_WORDS; wi++) begin
        for (int j = 0; j < 8; j++) begin
          hw[8*j +: 8] = header_byte(wi * 8 + j, seq_nib, frame_cnt);
        end
        frame_word(hw);
      end
      report_open = 1'b1;
    end
    // Words past the payload area are dropped but remembered in the flag.
    if (slot_cnt < SLOTS) begin
      frame_word(payload);
      slot_cnt++;
    end else begin
      spill_seen = 1'b1;
    end
    if (last) begin
      // Zero pad for a short packet, then the fixed zero fill.
      while (slot_cnt < SLOTS) begin
        frame_word(64'd0);
        slot_cnt++;
      end
      for (int f = 0; f < FILL_WORDS; f++) begin
        frame_word(64'd0);
      end
      // The closing word carries two zero bytes under the CRC, then the CRC.
      crc_acc = crc_feed(crc_acc, 8'h00);
      crc_acc = crc_feed(crc_acc, 8'h00);
      report_q.push_back('{{16'h0000, ~crc_acc, 16'h0000}, NBYTES_FINAL, 1'b1, spill_seen});
      seq_nib   = seq_nib + 4'd1;
      frame_cnt = frame_cnt + 8'd1;
      clear_report_state();
    end
  endtask

  // Offers one payload transaction on the slave side and waits for it to be
  // taken. Entered just after a rising edge; may idle first for a short burst.
  task automatic send_payload(input logic [63:0] payload, input logic last,
                              input logic typed, input logic [63:0] header_w0);
    int unsigned first_idx;
    @(negedge clk_i);
    if (src_gappy && $urandom_range(0, 5) == 0) begin
      s_axis_tvalid_i = 1'b0;
      repeat ($urandom_range(1, 14)) @(negedge clk_i);
    end
    s_axis_tvalid_i = 1'b1;
    s_axis_tdata_i  = payload;
    s_axis_tlast_i  = last;
    do @(posedge clk_i); while (!s_axis_tready_o);
    first_idx = report_q.size();
    predict_report(payload, last);
    // A hand-written header word replaces the computed one for this row.
    if (typed && report_q.size() > first_idx) begin
      report_q[first_idx].word = header_w0;
    end
    items_sent++;
  endtask

  function automatic logic [63:0] random_payload();
    case ($urandom_range(0, 9))
      0:       return 64'd0;
      1:       return '1;
      default: return {$urandom(), $urandom()};
    endcase
  endfunction

  // Per packet, each side either idles in bursts or runs without gaps; the
  // tail of the run is kept free of idling on both sides.
  task automatic pick_idling();
    if (items_sent + CALM_TAIL >= RANDOM_ITEMS) begin
      src_gappy = 1'b0;
      sink_calm = 1'b1;
    end else begin
      src_gappy = ($urandom_range(0, 3) != 0);
      sink_calm = ($urandom_range(0, 3) == 0);
    end
  endtask

  // Sink side: tready drops in random bursts.
  initial begin
    m_axis_tready_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (!sink_calm && $urandom_range(0, 4) == 0) begin
        m_axis_tready_i = 1'b0;
        repeat ($urandom_range(1, 14) - 1) @(negedge clk_i);
      end else begin
        m_axis_tready_i = 1'b1;
      end
    end
  end

  // Each report word taken on the master side is checked against the oldest
  // expectation, field by field.
  always @(posedge clk_i) begin
    report_beat_t exp_beat;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      if (report_q.size() == 0) begin
        report_mismatch($sformatf("unexpected report word %h", m_axis_tdata_o));
      end else begin
        exp_beat = report_q.pop_front();
        if (m_axis_tdata_o !== exp_beat.word) begin
          report_mismatch($sformatf("word %0d: report_word %h, expected %h",
                                    beats_seen, m_axis_tdata_o, exp_beat.word));
        end
        if (m_axis_tuser_o[3:0] !== exp_beat.nbytes) begin
          report_mismatch($sformatf("word %0d: byte_count %0d, expected %0d",
                                    beats_seen, m_axis_tuser_o[3:0], exp_beat.nbytes));
        end
        if (m_axis_tlast_o !== exp_beat.closing) begin
          report_mismatch($sformatf("word %0d: end_of_report %b, expected %b",
                                    beats_seen, m_axis_tlast_o, exp_beat.closing));
        end
        if (m_axis_tuser_o[4] !== exp_beat.spill) begin
          report_mismatch($sformatf("word %0d: overflow_flag %b, expected %b",
                                    beats_seen, m_axis_tuser_o[4], exp_beat.spill));
        end
      end
      beats_seen++;
    end
  end

  // Directed rows: single-word packets at the data extremes, short packets and
  // walking patterns. Header word 0 is typed in where each of the first four packets
  // opens, since it depends only on the sequence nibble.
  directed_row_t directed_rows[] = '{
    '{64'h0000_0000_0000_0000, 1'b1, 1'b1, 64'h4040_40FF_0791_0036},
    '{64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 1'b1, 64'h4040_40FF_0791_1036},
    '{64'h0123_4567_89AB_CDEF, 1'b0, 1'b1, 64'h4040_40FF_0791_2036},
    '{64'hFEDC_BA98_7654_3210, 1'b0, 1'b0, 64'h0},
    '{64'h8000_0000_0000_0001, 1'b1, 1'b0, 64'h0},
    '{64'hAAAA_AAAA_AAAA_AAAA, 1'b0, 1'b1, 64'h4040_40FF_0791_3036},
    '{64'h5555_5555_5555_5555, 1'b1, 1'b0, 64'h0},
    '{64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 1'b0, 64'h0},
    '{64'h0000_0000_0000_0000, 1'b1, 1'b0, 64'h0},
    '{64'h0000_0000_0000_00FF, 1'b1, 1'b0, 64'h0},
    '{64'hFF00_0000_0000_0000, 1'b1, 1'b0, 64'h0}
  };

  initial begin
    int unsigned pkt_len;
    int unsigned pkt_no;
    int unsigned pick;

    rst_ni          = 1'b0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i  = '0;
    s_axis_tlast_i  = 1'b0;
    src_gappy       = 1'b0;
    sink_calm       = 1'b0;
    mismatches      = 0;
    beats_seen      = 0;
    items_sent      = 0;
    seq_nib         = 4'd0;
    frame_cnt       = 8'd0;
    clear_report_state();

    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[r]) begin
      pick_idling();
      send_payload(directed_rows[r].payload, directed_rows[r].last,
                   directed_rows[r].typed, directed_rows[r].header_w0);
    end

    // Random packets. The first two fill the payload area exactly and overrun
    // it; after that most packets are short, some full, some overrunning, in
    // which case the closing transaction is itself a dropped one.
    pkt_no = 0;
    while (items_sent < RANDOM_ITEMS) begin
      pick = $urandom_range(0, 99);
      if (pkt_no == 0)      pkt_len = SLOTS;
      else if (pkt_no == 1) pkt_len = SLOTS + 2;
      else if (pick < 40)   pkt_len = 1;
      else if (pick < 75)   pkt_len = $urandom_range(2, SLOTS - 1);
      else if (pick < 88)   pkt_len = SLOTS;
      else                  pkt_len = $urandom_range(SLOTS + 1, SLOTS + 5);
      pick_idling();
      for (int i = 0; i < pkt_len; i++) begin
        send_payload(random_payload(), (i == pkt_len - 1), 1'b0, 64'h0);
      end
      pkt_no++;
    end

    @(negedge clk_i);
    s_axis_tvalid_i = 1'b0;
    s_axis_tlast_i  = 1'b0;

    // Drain, then give any stray words time to show up.
    while (report_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (report_q.size() != 0) begin
      report_mismatch($sformatf("%0d report words never arrived", report_q.size()));
    end

    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

[files.f]
rtl/core/srfc_pkg.sv
rtl/core/srfc_front.sv
rtl/core/srfc_queue.sv
rtl/core/srfc_back.sv
rtl/core/speaker_report_framer_crc32_core.sv
dv/tb_top.sv
